### hw/rtl/b64e_pkg.sv
package b64e_pkg;

	// Default depth of the group queue between front and back
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam int unsigned CHARS_PER_GROUP = 4;

	localparam logic [6:0] CHAR_PAD     = 7'h3D; // '='
	localparam logic [6:0] CHAR_PLUS    = 7'h2B; // '+'
	localparam logic [6:0] CHAR_SLASH   = 7'h2F; // '/'
	localparam logic [6:0] CHAR_MINUS   = 7'h2D; // '-'
	localparam logic [6:0] CHAR_UNDERSC = 7'h5F; // '_'
	localparam logic [6:0] CHAR_UPPER_A = 7'h41; // 'A'
	localparam logic [6:0] CHAR_LOWER_A = 7'h61; // 'a'
	localparam logic [6:0] CHAR_DIGIT_0 = 7'h30; // '0'

	// Pad counts carried with a group
	localparam logic [1:0] PAD_NONE = 2'd0;
	localparam logic [1:0] PAD_ONE  = 2'd1;
	localparam logic [1:0] PAD_TWO  = 2'd2;

	// One 24-bit group ready for serializing
	typedef struct packed {
		logic [23:0] grp;
		logic [1:0]  npad;
		logic        last;
	} b64e_group_t;

	// Queue status seen by front and back
	typedef struct packed {
		logic full;
		logic empty;
	} b64e_qstat_t;

	// Map a 6-bit value to its ASCII character
	function automatic logic [6:0] b64e_char(input logic [5:0] v, input logic url);
		logic [6:0] v7;
		v7 = {1'b0, v};
		if (v < 6'd26) begin
			return CHAR_UPPER_A + v7;
		end else if (v < 6'd52) begin
			return CHAR_LOWER_A + (v7 - 7'd26);
		end else if (v < 6'd62) begin
			return CHAR_DIGIT_0 + (v7 - 7'd52);
		end else if (v == 6'd62) begin
			return url ? CHAR_MINUS : CHAR_PLUS;
		end else begin
			return url ? CHAR_UNDERSC : CHAR_SLASH;
		end
	endfunction

endpackage

### hw/rtl/b64e_front.sv
module b64e_front
	import b64e_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  b64e_qstat_t qstat,
	output logic        push,
	output b64e_group_t push_grp
);

	logic [1:0]  cnt_q;
	logic [15:0] held_q;
	logic        accept;

	assign in_stall = qstat.full;
	assign accept   = in_valid && !in_stall;

	// Build the group; a count of three is taken as two
	always_comb begin
		push_grp = '0;
		push     = 1'b0;
		unique case (cnt_q)
			2'd0: begin
				push_grp.grp  = {data_byte, 16'h0000};
				push_grp.npad = PAD_TWO;
				push          = accept && last_byte;
			end
			2'd1: begin
				push_grp.grp  = {held_q[15:8], data_byte, 8'h00};
				push_grp.npad = PAD_ONE;
				push          = accept && last_byte;
			end
			default: begin
				push_grp.grp  = {held_q, data_byte};
				push_grp.npad = PAD_NONE;
				push          = accept;
			end
		endcase
		push_grp.last = last_byte;
	end

	// Pending byte count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (accept) begin
			if (push) begin
				cnt_q <= 2'd0;
			end else begin
				cnt_q <= cnt_q + 2'd1;
			end
		end
	end

	// Held bytes: first in the upper half, second in the lower
	always_ff @(posedge clk) begin
		if (accept && !push) begin
			if (cnt_q == 2'd0) begin
				held_q <= {data_byte, 8'h00};
			end else begin
				held_q <= {held_q[15:8], data_byte};
			end
		end
	end

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_byte) |=> (cnt_q == 2'd0))
		else $error("pending count not cleared after final beat");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("group pushed into full queue");

endmodule

### hw/rtl/b64e_queue.sv
module b64e_queue
	import b64e_pkg::*;
#(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  b64e_group_t push_grp,
	input  logic        pop,
	output b64e_group_t head,
	output b64e_qstat_t qstat
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	b64e_group_t   mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign qstat.full  = (cnt_q == CNT_FULL);
	assign qstat.empty = (cnt_q == '0);
	assign head        = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_grp;
		end
	end

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("pop from empty queue");

endmodule

### hw/rtl/b64e_back.sv
module b64e_back
	import b64e_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        url_safe,
	input  b64e_group_t head,
	input  b64e_qstat_t qstat,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [6:0]  out_char,
	output logic        last_char
);

	b64e_group_t cur_q;
	logic        busy_q;
	logic [1:0]  idx_q;
	logic        out_valid_q;
	logic [6:0]  char_q;
	logic        last_q;

	logic        adv;
	logic        final_char;
	logic        is_pad;
	logic [5:0]  sextet;
	logic [6:0]  ch;

	assign adv        = !out_valid_q || !out_stall;
	assign final_char = (idx_q == 2'd3);
	assign pop        = !qstat.empty && (!busy_q || (adv && final_char));

	// Pick the sextet, most significant first, and decide on padding
	always_comb begin
		unique case (idx_q)
			2'd0:    sextet = cur_q.grp[23:18];
			2'd1:    sextet = cur_q.grp[17:12];
			2'd2:    sextet = cur_q.grp[11:6];
			default: sextet = cur_q.grp[5:0];
		endcase
		is_pad = (final_char && cur_q.npad != PAD_NONE) ||
			(idx_q == 2'd2 && cur_q.npad == PAD_TWO);
		ch = is_pad ? CHAR_PAD : b64e_char(sextet, url_safe);
	end

	// Current group, char index and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= busy_q;
				if (busy_q) begin
					idx_q <= idx_q + 2'd1;
				end
			end
			if (pop) begin
				busy_q <= 1'b1;
				idx_q  <= 2'd0;
			end else if (adv && busy_q && final_char) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Output beat payload and group payload
	always_ff @(posedge clk) begin
		if (adv && busy_q) begin
			char_q <= ch;
			last_q <= cur_q.last && final_char;
		end
		if (pop) begin
			cur_q <= head;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = char_q;
	assign last_char = last_q;

	a_idx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (idx_q == 2'd0))
		else $error("char index moved with no group loaded");

endmodule

### hw/rtl/base64_encoder.sv
// Channel | Signals                                  | Direction
// --------+------------------------------------------+----------
// in      | in_valid, in_stall, data_byte, last_byte | sink
// out     | out_valid, out_stall, out_char, last_char| source
// cfg     | cfg_valid, cfg_ready, cfg_data           | sink
//
// A byte is taken every cycle until the group queue fills; each group of
// three bytes (or a final partial group) yields four characters, one per
// cycle while out_stall is low, out of the back serializer through its
// single-character output register. A completing byte is written to the
// queue, then its group is loaded, then its first character is registered.
// Reset is asynchronous active low and clears counts, pointers and valids.
// An output stall holds the character register; the queue keeps the front
// taking bytes until it is full, then in_stall rises.
module base64_encoder
	import b64e_pkg::*;
#(
	parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [6:0] out_char,
	output logic       last_char,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data
);

	logic        url_q;
	logic        push;
	logic        pop;
	b64e_group_t push_grp;
	b64e_group_t head;
	b64e_qstat_t qstat;

	// Alphabet select register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			url_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			url_q <= cfg_data;
		end
	end

	b64e_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.qstat    (qstat),
		.push     (push),
		.push_grp (push_grp)
	);

	b64e_queue #(
		.DEPTH(QDEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_grp(push_grp),
		.pop     (pop),
		.head    (head),
		.qstat   (qstat)
	);

	b64e_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.url_safe (url_q),
		.head     (head),
		.qstat    (qstat),
		.pop      (pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_char (out_char),
		.last_char(last_char)
	);

endmodule

### tb/sv/tb_base64_encoder.sv
module tb_base64_encoder
	import b64e_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_CYCLES = 3000;
	localparam int DRAIN_PAUSE     = 8;
	localparam int LONG_HOLD       = 150;

	// One character beat as it leaves the encoder
	typedef struct packed {
		logic [6:0] ch;
		logic       lc;
	} char_beat_t;

	// Directed row: alphabet, byte, final flag, optional hand-typed group
	typedef struct packed {
		logic        url;
		logic [7:0]  dbyte;
		logic        lastb;
		logic        typed;
		logic [31:0] chars;
		logic        clast;
	} dir_row_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	logic [7:0] data_byte = 8'h00;
	logic       last_byte = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [6:0] out_char;
	logic       last_char;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic       cfg_data  = 1'b0;

	// Encoder mirror state
	logic        url_mode  = 1'b0;
	logic [15:0] held_bytes = 16'h0000;
	logic [1:0]  held_cnt  = 2'd0;
	string       b64_alphabet =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	char_beat_t due_chars[$];
	dir_row_t   dir_rows[$];

	int mismatches = 0;
	int snd_idle   = 0;
	int rcv_stall  = 0;
	int idle_run   = 0;
	int hold_left  = 0;
	bit hold_taken = 1'b0;
	bit long_hold_req = 1'b0;

	base64_encoder DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_char  (out_char),
		.last_char (last_char),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		mismatches++;
	endtask

	// Append one expected character to the tail of the queue
	function automatic void queue_char(input char_beat_t beat);
		due_chars.insert(due_chars.size(), beat);
	endfunction

	// Append one directed row to the table
	function automatic void add_row(input dir_row_t r);
		dir_rows.insert(dir_rows.size(), r);
	endfunction

	// 6-bit value to ASCII under the current alphabet
	function automatic logic [6:0] sextet_ascii(input logic [5:0] v);
		logic [7:0] c;
		c = b64_alphabet[v];
		if (url_mode && v == 6'd62) return CHAR_MINUS;
		if (url_mode && v == 6'd63) return CHAR_UNDERSC;
		return c[6:0];
	endfunction

	// Advance the mirror by one byte; queue the characters it yields if asked
	function automatic void encode_byte(input logic [7:0] b, input logic l, input bit keep);
		logic [1:0]  cnt;
		logic [23:0] grp;
		int          n_sext;
		char_beat_t  beat;
		cnt = (held_cnt == 2'd3) ? 2'd2 : held_cnt;
		if (!l && cnt != 2'd2) begin
			if (cnt == 2'd0) begin
				held_bytes = {b, 8'h00};
			end else begin
				held_bytes = {held_bytes[15:8], b};
			end
			held_cnt = cnt + 2'd1;
			return;
		end
		case (cnt)
			2'd0: begin
				grp = {b, 16'h0000};
				n_sext = 2;
			end
			2'd1: begin
				grp = {held_bytes[15:8], b, 8'h00};
				n_sext = 3;
			end
			default: begin
				grp = {held_bytes, b};
				n_sext = 4;
			end
		endcase
		for (int k = 0; k < 4; k++) begin
			beat.ch = (k < n_sext) ? sextet_ascii(grp[23 - 6 * k -: 6]) : CHAR_PAD;
			beat.lc = (k == 3) && l;
			if (keep) queue_char(beat);
		end
		held_bytes = 16'h0000;
		held_cnt = 2'd0;
	endfunction

	// Offer one byte; valid stays up after the accepting edge
	task automatic send_byte(input logic [7:0] b, input logic l);
		while ($urandom_range(0, 99) < snd_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		last_byte <= l;
		do @(posedge clk); while (!(in_valid && !in_stall));
	endtask

	// Let every expected character out, then a short quiet pause
	task automatic wait_drain();
		in_valid <= 1'b0;
		while (due_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_PAUSE) @(posedge clk);
	endtask

	task automatic write_alphabet(input logic v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		url_mode = v;
	endtask

	// Random messages, 1..9 bytes each, values leaning on the extremes now and then
	task automatic send_messages(input int nbytes);
		int         sent;
		int         len;
		logic [7:0] b;
		sent = 0;
		while (sent < nbytes) begin
			len = $urandom_range(1, 9);
			for (int i = 0; i < len; i++) begin
				case ($urandom_range(0, 7))
					0: b = 8'h00;
					1: b = 8'hFF;
					default: b = 8'($urandom_range(0, 255));
				endcase
				send_byte(b, i == len - 1);
				encode_byte(b, i == len - 1, 1'b1);
			end
			sent += len;
		end
	endtask

	// Receiver: random stalls, plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (long_hold_req && !hold_taken) begin
			out_stall  <= 1'b1;
			hold_left  <= LONG_HOLD;
			hold_taken <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < rcv_stall);
		end
	end

	// Output check against the oldest expected character
	always @(posedge clk) begin
		char_beat_t exp_beat;
		if (arst_n && out_valid && !out_stall) begin
			if (due_chars.size() == 0) begin
				report_mismatch($sformatf("unexpected char %h last %b", out_char, last_char));
			end else begin
				exp_beat = due_chars.pop_front();
				if (out_char !== exp_beat.ch)
					report_mismatch($sformatf("out_char %h, want %h", out_char, exp_beat.ch));
				if (last_char !== exp_beat.lc)
					report_mismatch($sformatf("last_char %b, want %b", last_char, exp_beat.lc));
			end
		end
	end

	// Watchdog: too long without any beat on any channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			idle_run <= 0;
		end else if (idle_run >= WATCHDOG_CYCLES) begin
			$display("watchdog: no beat for %0d cycles", idle_run);
			$display("== FAIL ==");
			$finish;
		end else begin
			idle_run <= idle_run + 1;
		end
	end

	initial begin
		char_beat_t beat;
		// Directed table; typed rows carry the four characters of the group
		add_row('{1'b0, 8'h00, 1'b1, 1'b1, "AA==", 1'b1});
		add_row('{1'b0, 8'hFF, 1'b1, 1'b1, "/w==", 1'b1});
		add_row('{1'b0, 8'h00, 1'b0, 1'b0, 32'h0, 1'b0});
		add_row('{1'b0, 8'h00, 1'b1, 1'b1, "AAA=", 1'b1});
		add_row('{1'b0, 8'hFF, 1'b0, 1'b0, 32'h0, 1'b0});
		add_row('{1'b0, 8'hFF, 1'b1, 1'b1, "//8=", 1'b1});
		add_row('{1'b0, 8'h00, 1'b0, 1'b0, 32'h0, 1'b0});
		add_row('{1'b0, 8'h00, 1'b0, 1'b0, 32'h0, 1'b0});
		add_row('{1'b0, 8'h00, 1'b0, 1'b1, "AAAA", 1'b0});
		add_row('{1'b0, 8'hFF, 1'b0, 1'b0, 32'h0, 1'b0});
		add_row('{1'b0, 8'hFF, 1'b0, 1'b0, 32'h0, 1'b0});
		add_row('{1'b0, 8'hFF, 1'b1, 1'b1, "////", 1'b1});
		add_row('{1'b0, 8'hFB, 1'b0, 1'b0, 32'h0, 1'b0});
		add_row('{1'b0, 8'hEF, 1'b0, 1'b0, 32'h0, 1'b0});
		add_row('{1'b0, 8'hBE, 1'b1, 1'b1, "++++", 1'b1});
		add_row('{1'b0, 8'h4D, 1'b0, 1'b0, 32'h0, 1'b0});
		add_row('{1'b0, 8'h61, 1'b0, 1'b0, 32'h0, 1'b0});
		add_row('{1'b0, 8'h6E, 1'b1, 1'b0, 32'h0, 1'b0});
		// URL-safe alphabet
		add_row('{1'b1, 8'hFF, 1'b1, 1'b1, "_w==", 1'b1});
		add_row('{1'b1, 8'hFB, 1'b0, 1'b0, 32'h0, 1'b0});
		add_row('{1'b1, 8'hEF, 1'b0, 1'b0, 32'h0, 1'b0});
		add_row('{1'b1, 8'hBE, 1'b1, 1'b1, "----", 1'b1});
		add_row('{1'b1, 8'hA5, 1'b0, 1'b0, 32'h0, 1'b0});
		add_row('{1'b1, 8'h3C, 1'b1, 1'b0, 32'h0, 1'b0});

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, light idling on both sides
		snd_idle = 25;
		rcv_stall <= 25;
		foreach (dir_rows[i]) begin
			if (dir_rows[i].url != url_mode) begin
				wait_drain();
				write_alphabet(dir_rows[i].url);
			end
			send_byte(dir_rows[i].dbyte, dir_rows[i].lastb);
			encode_byte(dir_rows[i].dbyte, dir_rows[i].lastb, !dir_rows[i].typed);
			if (dir_rows[i].typed) begin
				for (int k = 0; k < 4; k++) begin
					beat.ch = dir_rows[i].chars[30 - 8 * k -: 7];
					beat.lc = (k == 3) && dir_rows[i].clast;
					queue_char(beat);
				end
			end
		end

		// No idling at all
		wait_drain();
		write_alphabet(1'b0);
		snd_idle = 0;
		rcv_stall <= 0;
		send_messages(45);

		// Sender mostly idle
		wait_drain();
		write_alphabet(1'b1);
		snd_idle = 83;
		rcv_stall <= 0;
		send_messages(45);

		// Receiver mostly stalled
		wait_drain();
		write_alphabet(1'b0);
		snd_idle = 0;
		rcv_stall <= 83;
		send_messages(45);

		// Both sides idle now and then
		wait_drain();
		write_alphabet(1'b1);
		snd_idle = 16;
		rcv_stall <= 16;
		send_messages(45);

		// Long receiver hold-off while bytes keep coming: input must back up
		wait_drain();
		write_alphabet(1'($urandom_range(0, 1)));
		snd_idle = 0;
		rcv_stall <= 0;
		long_hold_req <= 1'b1;
		send_messages(35);

		wait_drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
